// ----- rtl/assert_macros.svh -----
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CLK(lbl, !(cond))
`endif

// ----- rtl/eabv_pkg.sv -----
`default_nettype none
package eabv_pkg;
  localparam int unsigned InWidth = 17;
  localparam int unsigned OutFracBits = 14;
  localparam int unsigned OutWidth = OutFracBits + 2;
  localparam int unsigned TrigStages = 16;
  localparam int unsigned TrigFrac = 30;
  localparam int unsigned Xw = 33;
  localparam int unsigned Zw = 32;
  localparam int unsigned PipeDepth = TrigStages + 5;
  localparam logic signed [Xw-1:0] CordicGainInit = 33'sd652032874;
  localparam logic signed [17:0] AngleTurn = 18'sd46080;
  localparam logic signed [17:0] AngleHalf = 18'sd23040;
  localparam logic signed [17:0] AngleQuarter = 18'sd11520;

  typedef struct packed {
    logic signed [Xw-1:0] x;
    logic signed [Xw-1:0] y;
    logic signed [Zw-1:0] z;
    logic neg;
  } cord_t;

  function automatic logic signed [Zw-1:0] atan_lut(input logic [4:0] i);
    logic signed [Zw-1:0] r;
    case (i)
      5'd0: r = 32'sd754974720;  5'd1: r = 32'sd445687602;
      5'd2: r = 32'sd235489088;  5'd3: r = 32'sd119537938;
      5'd4: r = 32'sd60000934;   5'd5: r = 32'sd30029717;
      5'd6: r = 32'sd15018523;   5'd7: r = 32'sd7509720;
      5'd8: r = 32'sd3754917;    5'd9: r = 32'sd1877466;
      5'd10: r = 32'sd938734;    5'd11: r = 32'sd469367;
      5'd12: r = 32'sd234684;    5'd13: r = 32'sd117342;
      5'd14: r = 32'sd58671;     5'd15: r = 32'sd29335;
      5'd16: r = 32'sd14668;     5'd17: r = 32'sd7334;
      5'd18: r = 32'sd3667;      5'd19: r = 32'sd1833;
      5'd20: r = 32'sd917;       5'd21: r = 32'sd458;
      5'd22: r = 32'sd229;       5'd23: r = 32'sd115;
      5'd24: r = 32'sd57;        5'd25: r = 32'sd29;
      5'd26: r = 32'sd14;        5'd27: r = 32'sd7;
      5'd28: r = 32'sd4;         5'd29: r = 32'sd2;
      5'd30: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // q2.30 product rounded half away from zero
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic [63:0] m;
    begin
      p = a * b;
      m = p[63] ? 64'(-p) : 64'(p);
      m = (m + 64'(1) * (64'd1 << (TrigFrac - 1))) >> TrigFrac;
      return p[63] ? -32'(m) : 32'(m);
    end
  endfunction

  // round to output fraction and saturate
  function automatic logic [OutWidth-1:0] to_out(input logic signed [33:0] v);
    logic [33:0] m;
    logic [33:0] r;
    begin
      m = v[33] ? 34'(-v) : 34'(v);
      m = (m + (34'd1 << (TrigFrac - OutFracBits - 1))) >> (TrigFrac - OutFracBits);
      if (m > (34'd1 << OutFracBits)) m = 34'd1 << OutFracBits;
      r = v[33] ? 34'(-m) : m;
      return r[OutWidth-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/eabv_cell.sv -----
`default_nettype none
module eabv_cell (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire logic [4:0] stage_i,
  input  wire eabv_pkg::cord_t a_i,
  output eabv_pkg::cord_t a_o
);
  import eabv_pkg::*;
  cord_t d;
  // one micro-rotation, floor shifts
  always_comb begin
    d.neg = a_i.neg;
    if (!a_i.z[Zw-1]) begin
      d.x = a_i.x - (a_i.y >>> stage_i);
      d.y = a_i.y + (a_i.x >>> stage_i);
      d.z = a_i.z - atan_lut(stage_i);
    end else begin
      d.x = a_i.x + (a_i.y >>> stage_i);
      d.y = a_i.y - (a_i.x >>> stage_i);
      d.z = a_i.z + atan_lut(stage_i);
    end
  end
  // hand on to the next cell only when the pipe moves
  always_ff @(posedge clk_i) begin
    if (en_i) a_o <= d;
  end
endmodule
`default_nettype wire

// ----- rtl/eabv_cordic.sv -----
`default_nettype none
module eabv_cordic (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire logic signed [eabv_pkg::InWidth-1:0] ang_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);
  import eabv_pkg::*;
  cord_t chain [TrigStages+1];
  cord_t first_q;
  logic signed [17:0] a, w;
  logic neg;
  logic signed [Xw-1:0] xc, yc;
  // wrap to one turn and fold to plus or minus a quarter
  always_comb begin
    a = 18'(ang_i);
    if (a < 0) a = a + AngleTurn;
    if (a < 0) a = a + AngleTurn;
    if (a >= AngleTurn) a = a - AngleTurn;
    if (a >= AngleHalf) a = a - AngleTurn;
    w = a; neg = 1'b0;
    if (a > AngleQuarter) begin w = a - AngleHalf; neg = 1'b1; end
    else if (a < -AngleQuarter) begin w = a + AngleHalf; neg = 1'b1; end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      first_q.x <= CordicGainInit;
      first_q.y <= '0;
      first_q.z <= Zw'(w) <<< 17;
      first_q.neg <= neg;
    end
  end
  assign chain[0] = first_q;
  for (genvar g = 0; g < TrigStages; g++) begin : g_cell
    eabv_cell u_cell (.clk_i, .en_i, .stage_i(5'(g)), .a_i(chain[g]), .a_o(chain[g+1]));
  end
  // clamp and unfold
  always_comb begin
    xc = chain[TrigStages].x;
    yc = chain[TrigStages].y;
    if (xc > 33'sd1073741824) xc = 33'sd1073741824;
    if (xc < -33'sd1073741824) xc = -33'sd1073741824;
    if (yc > 33'sd1073741824) yc = 33'sd1073741824;
    if (yc < -33'sd1073741824) yc = -33'sd1073741824;
    cos_o = chain[TrigStages].neg ? -32'(xc) : 32'(xc);
    sin_o = chain[TrigStages].neg ? -32'(yc) : 32'(yc);
  end
endmodule
`default_nettype wire

// ----- rtl/euler_angles_to_basis_vectors.sv -----
// channel | signals                                   | dir
// in      | in_valid_i in_ready_o pitch/yaw/roll_angle_i | in
// out     | out_valid_o out_ready_i nine vector fields | out
// one word per cycle while the output is not stalled; trig stages plus five register
// stages in all, and a result is offered once its word has passed through all of them
// the pipeline advances as a whole when the output stage is free or taken
// a stalled output holds every stage; reset clears the valid bits only
`default_nettype none
`include "assert_macros.svh"
module euler_angles_to_basis_vectors (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic signed [eabv_pkg::InWidth-1:0] pitch_angle_i,
  input  wire logic signed [eabv_pkg::InWidth-1:0] yaw_angle_i,
  input  wire logic signed [eabv_pkg::InWidth-1:0] roll_angle_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic signed [eabv_pkg::OutWidth-1:0] left_x_o,
  output logic signed [eabv_pkg::OutWidth-1:0] left_y_o,
  output logic signed [eabv_pkg::OutWidth-1:0] left_z_o,
  output logic signed [eabv_pkg::OutWidth-1:0] up_x_o,
  output logic signed [eabv_pkg::OutWidth-1:0] up_y_o,
  output logic signed [eabv_pkg::OutWidth-1:0] up_z_o,
  output logic signed [eabv_pkg::OutWidth-1:0] front_x_o,
  output logic signed [eabv_pkg::OutWidth-1:0] front_y_o,
  output logic signed [eabv_pkg::OutWidth-1:0] front_z_o
);
  import eabv_pkg::*;
  logic adv;
  logic [PipeDepth-1:0] vld_q;
  logic signed [31:0] sx, cx, sy, cy, sz, cz;
  logic signed [31:0] sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
  logic signed [31:0] sxsy_q, cxsy_q, cycz_q, cxsz_q, sxsz_q, cysz_q, cxcz_q, sxcz_q,
                      sxcy_q, cxcy_q, sy2_q, cz2_q, sz2_q;
  logic signed [31:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q, p8_q, p9_q, p10_q,
                      p11_q, p12_q;
  logic signed [31:0] cxcy2_q;
  logic [OutWidth-1:0] o_q [9];

  // whole pipe moves when the output is free or taken
  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[PipeDepth-2:0], in_valid_i};
  end

  // trig chains; they only ever advance with the pipe
  eabv_cordic u_px (.clk_i, .en_i(adv), .ang_i(pitch_angle_i), .sin_o(sx), .cos_o(cx));
  eabv_cordic u_py (.clk_i, .en_i(adv), .ang_i(yaw_angle_i), .sin_o(sy), .cos_o(cy));
  eabv_cordic u_pz (.clk_i, .en_i(adv), .ang_i(roll_angle_i), .sin_o(sz), .cos_o(cz));

  // products, at most one multiply per register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q <= sx; cx_q <= cx; sy_q <= sy; cy_q <= cy; sz_q <= sz; cz_q <= cz;
      sxsy_q <= qmul(sx_q, sy_q); cxsy_q <= qmul(cx_q, sy_q);
      cycz_q <= qmul(cy_q, cz_q); cxsz_q <= qmul(cx_q, sz_q);
      sxsz_q <= qmul(sx_q, sz_q); cysz_q <= qmul(cy_q, sz_q);
      cxcz_q <= qmul(cx_q, cz_q); sxcz_q <= qmul(sx_q, cz_q);
      sxcy_q <= qmul(sx_q, cy_q); cxcy_q <= qmul(cx_q, cy_q);
      sy2_q <= sy_q; cz2_q <= cz_q; sz2_q <= sz_q;
      p1_q <= cycz_q; p2_q <= qmul(sxsy_q, cz2_q); p3_q <= cxsz_q;
      p4_q <= qmul(cxsy_q, cz2_q); p5_q <= sxsz_q; p6_q <= cysz_q;
      p7_q <= qmul(sxsy_q, sz2_q); p8_q <= cxcz_q; p9_q <= qmul(cxsy_q, sz2_q);
      p10_q <= sxcz_q; p11_q <= sy2_q; p12_q <= sxcy_q;
      o_q[0] <= to_out(34'(p1_q));
      o_q[1] <= to_out(34'(p2_q) + 34'(p3_q));
      o_q[2] <= to_out(34'(p5_q) - 34'(p4_q));
      o_q[3] <= to_out(-34'(p6_q));
      o_q[4] <= to_out(34'(p8_q) - 34'(p7_q));
      o_q[5] <= to_out(34'(p9_q) + 34'(p10_q));
      o_q[6] <= to_out(34'(p11_q));
      o_q[7] <= to_out(-34'(p12_q));
      o_q[8] <= to_out(34'(cxcy2_q));
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) cxcy2_q <= cxcy_q;
  end

  assign left_x_o = o_q[0];  assign left_y_o = o_q[1];  assign left_z_o = o_q[2];
  assign up_x_o = o_q[3];    assign up_y_o = o_q[4];    assign up_z_o = o_q[5];
  assign front_x_o = o_q[6]; assign front_y_o = o_q[7]; assign front_z_o = o_q[8];

  `ASSERT_CLK(a_stall_hold, (out_valid_o && !out_ready_i) |=> out_valid_o)
  `ASSERT_NEVER(a_ready_free, !out_valid_o && !in_ready_o)
  `ASSERT_CLK(a_fill, (in_valid_i && in_ready_o && $past(vld_q == '0)) |-> !out_valid_o)
endmodule
`default_nettype wire

// ----- tb/tb_euler_angles_to_basis_vectors.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_euler_angles_to_basis_vectors;
  import eabv_pkg::*;

  typedef logic [8:0][OutWidth-1:0] basis_t;

  localparam longint TurnUnits = 46080;
  localparam longint HalfUnits = 23040;
  localparam longint QuarterUnits = 11520;
  localparam longint CycleLimit = 200000;

  localparam longint ArcTanDeg [16] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335
  };

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [InWidth-1:0] pitch_angle_i, yaw_angle_i, roll_angle_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [OutWidth-1:0] left_x_o, left_y_o, left_z_o;
  logic signed [OutWidth-1:0] up_x_o, up_y_o, up_z_o;
  logic signed [OutWidth-1:0] front_x_o, front_y_o, front_z_o;

  basis_t basis_q[$];
  int unsigned fail_count;
  int unsigned words_sent;
  int unsigned words_checked;
  longint cycle_count;
  bit no_idle;
  bit hold_request;
  int hold_left;
  int stall_left;

  euler_angles_to_basis_vectors uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .pitch_angle_i(pitch_angle_i), .yaw_angle_i(yaw_angle_i),
    .roll_angle_i(roll_angle_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .left_x_o(left_x_o), .left_y_o(left_y_o), .left_z_o(left_z_o),
    .up_x_o(up_x_o), .up_y_o(up_y_o), .up_z_o(up_z_o),
    .front_x_o(front_x_o), .front_y_o(front_y_o), .front_z_o(front_z_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // wrap, fold and rotate one angle into q2.30 sine and cosine
  function automatic void angle_sin_cos(input logic signed [InWidth-1:0] raw,
                                        output longint s, output longint c);
    longint a, x, y, z, nx;
    bit neg;
    a = longint'(raw);
    a = (a + 2 * TurnUnits) % TurnUnits;
    if (a >= HalfUnits) a -= TurnUnits;
    neg = 1'b0;
    if (a > QuarterUnits) begin
      a -= HalfUnits;
      neg = 1'b1;
    end else if (a < -QuarterUnits) begin
      a += HalfUnits;
      neg = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = a * 131072;
    for (int i = 0; i < TrigStages; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ArcTanDeg[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ArcTanDeg[i];
      end
      x = nx;
    end
    if (x > (64'sd1 <<< TrigFrac)) x = 64'sd1 <<< TrigFrac;
    if (x < -(64'sd1 <<< TrigFrac)) x = -(64'sd1 <<< TrigFrac);
    if (y > (64'sd1 <<< TrigFrac)) y = 64'sd1 <<< TrigFrac;
    if (y < -(64'sd1 <<< TrigFrac)) y = -(64'sd1 <<< TrigFrac);
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  // shift right rounding half away from zero
  function automatic longint round_away(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint fix_mul(input longint a, input longint b);
    return round_away(a * b, TrigFrac);
  endfunction

  function automatic logic [OutWidth-1:0] to_q14(input longint v);
    longint r;
    r = round_away(v, TrigFrac - OutFracBits);
    if (r > (64'sd1 <<< OutFracBits)) r = 64'sd1 <<< OutFracBits;
    if (r < -(64'sd1 <<< OutFracBits)) r = -(64'sd1 <<< OutFracBits);
    return r[OutWidth-1:0];
  endfunction

  // columns of rx * ry * rz: left, up, front
  function automatic basis_t camera_basis(input logic signed [InWidth-1:0] p,
                                          input logic signed [InWidth-1:0] yw,
                                          input logic signed [InWidth-1:0] rl);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    basis_t b;
    angle_sin_cos(p, sx, cx);
    angle_sin_cos(yw, sy, cy);
    angle_sin_cos(rl, sz, cz);
    sxsy = fix_mul(sx, sy);
    cxsy = fix_mul(cx, sy);
    b[0] = to_q14(fix_mul(cy, cz));
    b[1] = to_q14(fix_mul(sxsy, cz) + fix_mul(cx, sz));
    b[2] = to_q14(-fix_mul(cxsy, cz) + fix_mul(sx, sz));
    b[3] = to_q14(-fix_mul(cy, sz));
    b[4] = to_q14(-fix_mul(sxsy, sz) + fix_mul(cx, cz));
    b[5] = to_q14(fix_mul(cxsy, sz) + fix_mul(sx, cz));
    b[6] = to_q14(sy);
    b[7] = to_q14(-fix_mul(sx, cy));
    b[8] = to_q14(fix_mul(cx, cy));
    return b;
  endfunction

  // send one word, with an optional idle burst first
  task automatic send_angles(input logic signed [InWidth-1:0] p,
                             input logic signed [InWidth-1:0] yw,
                             input logic signed [InWidth-1:0] rl);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pitch_angle_i <= p;
    yaw_angle_i <= yw;
    roll_angle_i <= rl;
    do @(posedge clk_i); while (!in_ready_o);
    basis_q.push_back(camera_basis(p, yw, rl));
    words_sent++;
  endtask

  function automatic logic signed [InWidth-1:0] rand_angle(input bit full);
    if (full) return InWidth'($urandom);
    return InWidth'($urandom_range(0, 2 * 46080) - 46080);
  endfunction

  task automatic test_directed();
    logic signed [InWidth-1:0] marks [12];
    marks = '{0, 11520, -11520, 23040, -23040, 46080, -46080,
              65535, -65536, 47360, 11519, -23041};
    foreach (marks[i]) send_angles(marks[i], marks[(i + 3) % 12], marks[(i + 7) % 12]);
    send_angles(11520, 11520, 11520);
    send_angles(-11520, 23040, -23040);
    send_angles(5760, -5760, 128);
    send_angles(1, -1, 0);
  endtask

  task automatic test_random(input int n);
    repeat (n) send_angles(rand_angle($urandom_range(0, 1)),
                           rand_angle($urandom_range(0, 1)),
                           rand_angle($urandom_range(0, 1)));
  endtask

  // receiver stops for a long stretch while words keep coming
  task automatic test_backpressure();
    hold_request = 1'b1;
    test_random(60);
  endtask

  task automatic test_streaming();
    no_idle = 1'b1;
    test_random(150);
  endtask

  // receiver side: random stalls and one long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 200;
      out_ready_i <= 1'b0;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    basis_t got, want;
    string names [9];
    names = '{"left_x", "left_y", "left_z", "up_x", "up_y", "up_z",
              "front_x", "front_y", "front_z"};
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {front_z_o, front_y_o, front_x_o, up_z_o, up_y_o, up_x_o,
             left_z_o, left_y_o, left_x_o};
      if (basis_q.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = basis_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want[i]) begin
            $error("%s: expected %0d, got %0d", names[i],
                   $signed(want[i]), $signed(got[i]));
            fail_count++;
          end
        end
        words_checked++;
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    fail_count = 0;
    words_sent = 0;
    words_checked = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    hold_request = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pitch_angle_i = '0;
    yaw_angle_i = '0;
    roll_angle_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(220);
    test_backpressure();
    test_streaming();
    in_valid_i <= 1'b0;

    while (basis_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);

    $display("sent %0d angle words, checked %0d basis words", words_sent, words_checked);
    $display("covered fold edges, wrap past one turn, long output hold and full rate");
    if (fail_count == 0 && basis_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/eabv_pkg.sv
rtl/eabv_cell.sv
rtl/eabv_cordic.sv
rtl/euler_angles_to_basis_vectors.sv
tb/tb_euler_angles_to_basis_vectors.sv
